// ===== hdl/dsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants of the debug stream deframer.
// ----------------------------------------------------------------------------
package dsd_pkg;

	localparam int unsigned HDR_BYTES   = 12;
	localparam int unsigned LEN_W       = 24;
	localparam int unsigned APB_ADDR_W  = 4;
	localparam int unsigned APB_DATA_W  = 32;

	localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

	localparam logic [31:0]      MAGIC_WORD_RST   = 32'd0;
	localparam logic [7:0]       PROTO_VER_RST    = 8'd1;
	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST  = 24'd65536;

	// header byte positions
	localparam logic [3:0] HB_MAGIC3   = 4'd3;
	localparam logic [3:0] HB_VERSION  = 4'd4;
	localparam logic [3:0] HB_OPCODE   = 4'd5;
	localparam logic [3:0] HB_FLAGS    = 4'd6;
	localparam logic [3:0] HB_RESERVED = 4'd7;
	localparam logic [3:0] HB_LEN0     = 4'd8;
	localparam logic [3:0] HB_LEN1     = 4'd9;
	localparam logic [3:0] HB_LEN2     = 4'd10;
	localparam logic [3:0] HB_LEN3     = 4'd11;

	typedef enum logic [1:0] {
		REG_MAGIC_WORD  = 2'd0,
		REG_PROTO_VER   = 2'd1,
		REG_MAX_PAYLOAD = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	localparam logic CMD_STREAM = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] in_byte;
	} in_req_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       opcode;
		logic [7:0]       flag_bits;
		logic [LEN_W-1:0] payload_length;
		logic [7:0]       data_byte;
		logic             last;
	} out_res_t;

	typedef struct packed {
		logic [31:0]      magic_word;
		logic [7:0]       protocol_version;
		logic [LEN_W-1:0] max_payload;
	} cfg_t;

endpackage

// ===== hdl/dsd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_cfg_regs
// APB register file holding the expected magic, version and length limit.
// ----------------------------------------------------------------------------
module dsd_cfg_regs
	import dsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [31:0]      magic_word_q;
	logic [7:0]       proto_ver_q;
	logic [LEN_W-1:0] max_payload_q;
	logic             wr_en;
	reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q  <= MAGIC_WORD_RST;
			proto_ver_q   <= PROTO_VER_RST;
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (wr_en) begin
			case (idx)
				REG_MAGIC_WORD:  magic_word_q  <= pwdata;
				REG_PROTO_VER:   proto_ver_q   <= pwdata[7:0];
				REG_MAX_PAYLOAD: max_payload_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAGIC_WORD:  prdata = magic_word_q;
			REG_PROTO_VER:   prdata = {24'd0, proto_ver_q};
			REG_MAX_PAYLOAD: prdata = {{(APB_DATA_W-LEN_W){1'b0}}, max_payload_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.magic_word       = magic_word_q;
	assign cfg.protocol_version = proto_ver_q;
	assign cfg.max_payload      = max_payload_q;

endmodule

// ===== hdl/dsd_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_in_stage
// Input register: captures one request per cycle while not stalled and hands it to the core.
// ----------------------------------------------------------------------------
module dsd_in_stage
	import dsd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  in_req_t in_req,
	output logic    in_stall,
	input  logic    down_ready,
	output logic    fire,
	output in_req_t req_s1
);

	logic valid_s1;

	// request moves into the core when the result register can take it
	assign fire     = valid_s1 && down_ready;
	assign in_stall = valid_s1 && !down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_req;
		end
	end

endmodule

// ===== hdl/dsd_frame_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_frame_core
// Framer state: header collection, checks, payload countdown, sticky error.
// ----------------------------------------------------------------------------
module dsd_frame_core
	import dsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     fire,
	input  in_req_t  req_s1,
	output logic     res_valid,
	output out_res_t res
);

	phase_t           phase_q, phase_n;
	logic [3:0]       hdr_cnt_q, hdr_cnt_n, cnt_eff;
	logic [LEN_W-1:0] bytes_left_q, bytes_left_n, bl_dec;
	logic [31:0]      magic_q, magic_n;
	logic [7:0]       version_q, version_n;
	logic [7:0]       opcode_q, opcode_n;
	logic [7:0]       flags_q, flags_n;
	logic [LEN_W-1:0] len_lo_q, len_lo_n;
	logic             len_hi_q, len_hi_n;
	logic             hdr_err;
	logic [7:0]       b;

	assign b      = req_s1.in_byte;
	assign bl_dec = bytes_left_q - LEN_W'(bytes_left_q != '0);

	always_comb begin
		phase_n      = phase_q;
		hdr_cnt_n    = hdr_cnt_q;
		bytes_left_n = bytes_left_q;
		magic_n      = magic_q;
		version_n    = version_q;
		opcode_n     = opcode_q;
		flags_n      = flags_q;
		len_lo_n     = len_lo_q;
		len_hi_n     = len_hi_q;
		cnt_eff      = (hdr_cnt_q >= 4'(HDR_BYTES)) ? 4'd0 : hdr_cnt_q;
		hdr_err      = 1'b0;
		res_valid    = 1'b0;
		res          = '0;
		res.kind     = KIND_PAYLOAD;

		if (fire) begin
			if (req_s1.command == CMD_CLEAR) begin
				phase_n      = PH_HEADER;
				hdr_cnt_n    = '0;
				bytes_left_n = '0;
			end else begin
				case (phase_q)
					PH_ERROR: ;
					PH_PAYLOAD: begin
						res_valid    = 1'b1;
						res.kind     = KIND_PAYLOAD;
						res.data_byte = b;
						res.last     = (bytes_left_q <= LEN_W'(1));
						bytes_left_n = bl_dec;
						if (bl_dec == '0) begin
							phase_n   = PH_HEADER;
							hdr_cnt_n = '0;
						end
					end
					default: begin
						phase_n = PH_HEADER;
						case (cnt_eff)
							HB_VERSION:  version_n = b;
							HB_OPCODE:   opcode_n  = b;
							HB_FLAGS:    flags_n   = b;
							HB_RESERVED: ;
							HB_LEN0:     len_lo_n[7:0]   = b;
							HB_LEN1:     len_lo_n[15:8]  = b;
							HB_LEN2:     len_lo_n[23:16] = b;
							HB_LEN3:     len_hi_n = (b != 8'd0);
							default:     magic_n[{cnt_eff[1:0], 3'b000} +: 8] = b;
						endcase
						hdr_cnt_n = cnt_eff + 4'd1;
						if (cnt_eff == HB_LEN3) begin
							hdr_cnt_n = '0;
							// magic and version complete; length top byte is this request
							hdr_err = (magic_q != cfg.magic_word) ||
								(version_q != cfg.protocol_version) ||
								len_hi_n || (len_lo_q > cfg.max_payload);
							res_valid = 1'b1;
							res.opcode    = opcode_q;
							res.flag_bits = flags_q;
							res.payload_length = len_hi_n ? LEN_SAT : len_lo_q;
							if (hdr_err) begin
								res.kind     = KIND_ERROR;
								phase_n      = PH_ERROR;
								bytes_left_n = '0;
							end else if (len_lo_q == '0) begin
								res.kind     = KIND_HEADER;
								res.last     = 1'b1;
								bytes_left_n = '0;
							end else begin
								res.kind     = KIND_HEADER;
								bytes_left_n = len_lo_q;
								phase_n      = PH_PAYLOAD;
							end
						end
					end
				endcase
			end
		end

		// payload results carry the current frame's header fields
		if (phase_q == PH_PAYLOAD) begin
			res.opcode         = opcode_q;
			res.flag_bits      = flags_q;
			res.payload_length = len_hi_q ? LEN_SAT : len_lo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			hdr_cnt_q    <= '0;
			bytes_left_q <= '0;
		end else begin
			phase_q      <= phase_n;
			hdr_cnt_q    <= hdr_cnt_n;
			bytes_left_q <= bytes_left_n;
		end
	end

	// header fields are rewritten before any result uses them
	always_ff @(posedge clk) begin
		magic_q   <= magic_n;
		version_q <= version_n;
		opcode_q  <= opcode_n;
		flags_q   <= flags_n;
		len_lo_q  <= len_lo_n;
		len_hi_q  <= len_hi_n;
	end

endmodule

// ===== hdl/dsd_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_out_stage
// Result register: holds a result while the receiver stalls.
// ----------------------------------------------------------------------------
module dsd_out_stage
	import dsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     res_valid,
	input  out_res_t res,
	output logic     ready,
	output logic     out_valid,
	output out_res_t out_res,
	input  logic     out_stall
);

	logic     valid_s2;
	out_res_t res_s2;

	assign ready     = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== hdl/debug_stream_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debug_stream_deframer_unit
// Streams length-prefixed frames: checks a 12-byte header, then passes bytes.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  in        in_valid / in_stall     in_req  (command, in_byte)
//  out       out_valid / out_stall   out_res (kind .. last)
//  config    psel/penable/pwrite     paddr, pwdata, prdata, pready
//
//  one request per cycle while in_stall is low
//  the input register, framer state update and result register form the path
//  a stalled result holds in the result register; in_stall rises only when
//  the input register is also full
//  reset clears the framer to the header phase and loads register defaults
// ----------------------------------------------------------------------------
module debug_stream_deframer_unit
	import dsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_req_t               in_req,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_res_t              out_res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t     cfg;
	logic     fire;
	logic     down_ready;
	in_req_t  req_s1;
	logic     res_valid;
	out_res_t res;

	dsd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dsd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_req     (in_req),
		.in_stall   (in_stall),
		.down_ready (down_ready),
		.fire       (fire),
		.req_s1     (req_s1)
	);

	dsd_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.req_s1    (req_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	dsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.ready     (down_ready),
		.out_valid (out_valid),
		.out_res   (out_res),
		.out_stall (out_stall)
	);

endmodule

// ===== hdl/dsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_checker
// Port-level checks of the deframer result stream.
// ----------------------------------------------------------------------------
module dsd_checker
	import dsd_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     out_valid,
	input logic     out_stall,
	input out_res_t out_res
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_res))
		else $error("result changed while stalled");

	a_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.kind == KIND_ERROR |->
			!out_res.last && out_res.data_byte == 8'd0)
		else $error("error result with last or data set");

	a_hdr_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.kind == KIND_HEADER |->
			out_res.data_byte == 8'd0 &&
			out_res.last == (out_res.payload_length == '0))
		else $error("header result last flag does not match length");

	a_payload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.kind == KIND_PAYLOAD |-> out_res.payload_length != '0)
		else $error("payload byte from an empty frame");

endmodule

bind debug_stream_deframer_unit dsd_checker u_dsd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_res   (out_res)
);

// ===== verif/debug_stream_deframer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debug_stream_deframer_unit_test
// Drives framed byte streams, clear commands and noise into the deframer,
// predicts every header, payload and error result, and checks them in order
// across several register settings and idle patterns.
// ----------------------------------------------------------------------------
module debug_stream_deframer_unit_test;
	import dsd_pkg::*;

	localparam int unsigned QUIET_LIMIT = 20000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam logic [APB_ADDR_W-1:0] ADDR_MAGIC    = {REG_MAGIC_WORD, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_VERSION  = {REG_PROTO_VER, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LEN  = {REG_MAX_PAYLOAD, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 4'hC;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// tracks the framer state and the results it must produce
	class frame_tracker;
		logic [31:0]      magic_cfg;
		logic [7:0]       version_cfg;
		logic [LEN_W-1:0] max_len_cfg;

		phase_t           phase;
		logic [3:0]       hdr_pos;
		logic [31:0]      magic_rx;
		logic [7:0]       version_rx;
		logic [7:0]       opcode_rx;
		logic [7:0]       flags_rx;
		logic [31:0]      length_rx;
		logic [LEN_W-1:0] remaining;

		out_res_t pending_results[$];
		int unsigned mismatches;
		int unsigned n_header;
		int unsigned n_payload;
		int unsigned n_error;

		function new();
			magic_cfg   = MAGIC_WORD_RST;
			version_cfg = PROTO_VER_RST;
			max_len_cfg = MAX_PAYLOAD_RST;
			clear_state();
		endfunction

		function void clear_state();
			phase      = PH_HEADER;
			hdr_pos    = '0;
			magic_rx   = '0;
			version_rx = '0;
			opcode_rx  = '0;
			flags_rx   = '0;
			length_rx  = '0;
			remaining  = '0;
		endfunction

		function void write_reg(logic [APB_ADDR_W-1:0] addr, logic [31:0] data);
			case (addr[APB_ADDR_W-1:2])
				REG_MAGIC_WORD:  magic_cfg = data;
				REG_PROTO_VER:   version_cfg = data[7:0];
				REG_MAX_PAYLOAD: max_len_cfg = data[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function out_res_t make_result(kind_t k, logic [7:0] d, logic l);
			out_res_t r;
			r.kind           = k;
			r.opcode         = opcode_rx;
			r.flag_bits      = flags_rx;
			r.payload_length = (length_rx > {8'h00, LEN_SAT}) ? LEN_SAT : length_rx[LEN_W-1:0];
			r.data_byte      = d;
			r.last           = l;
			return r;
		endfunction

		function void note_request(in_req_t req);
			logic [7:0] b;
			b = req.in_byte;
			if (req.command == CMD_CLEAR) begin
				clear_state();
			end else if (phase == PH_ERROR) begin
				// sticky error drops the byte
			end else if (phase == PH_PAYLOAD) begin
				pending_results.push_back(make_result(KIND_PAYLOAD, b, remaining <= 1));
				n_payload++;
				if (remaining > 0)
					remaining--;
				if (remaining == 0) begin
					phase   = PH_HEADER;
					hdr_pos = '0;
				end
			end else begin
				phase = PH_HEADER;
				if (hdr_pos >= HDR_BYTES)
					hdr_pos = '0;
				if (hdr_pos <= HB_MAGIC3)
					magic_rx[8*hdr_pos +: 8] = b;
				else if (hdr_pos == HB_VERSION)
					version_rx = b;
				else if (hdr_pos == HB_OPCODE)
					opcode_rx = b;
				else if (hdr_pos == HB_FLAGS)
					flags_rx = b;
				else if (hdr_pos != HB_RESERVED)
					length_rx[8*(hdr_pos - HB_LEN0) +: 8] = b;
				hdr_pos++;
				if (hdr_pos >= HDR_BYTES) begin
					hdr_pos = '0;
					if (magic_rx != magic_cfg || version_rx != version_cfg ||
					    length_rx > {8'h00, max_len_cfg}) begin
						phase     = PH_ERROR;
						remaining = '0;
						pending_results.push_back(make_result(KIND_ERROR, 8'h00, 1'b0));
						n_error++;
					end else if (length_rx == 0) begin
						remaining = '0;
						pending_results.push_back(make_result(KIND_HEADER, 8'h00, 1'b1));
						n_header++;
					end else begin
						remaining = length_rx[LEN_W-1:0];
						phase     = PH_PAYLOAD;
						pending_results.push_back(make_result(KIND_HEADER, 8'h00, 1'b0));
						n_header++;
					end
				end
			end
		endfunction

		function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
			if (got_v !== exp_v) begin
				$error("%s expected %0h got %0h", name, exp_v, got_v);
				mismatches++;
			end
		endfunction

		function void check_result(out_res_t got);
			out_res_t exp_r;
			if (pending_results.size() == 0) begin
				$error("result kind %0d arrived with none expected", got.kind);
				mismatches++;
				return;
			end
			exp_r = pending_results.pop_front();
			compare_field("kind", exp_r.kind, got.kind);
			compare_field("opcode", exp_r.opcode, got.opcode);
			compare_field("flag_bits", exp_r.flag_bits, got.flag_bits);
			compare_field("payload_length", exp_r.payload_length, got.payload_length);
			compare_field("data_byte", exp_r.data_byte, got.data_byte);
			compare_field("last", exp_r.last, got.last);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_req_t               in_req = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_res_t              out_res;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	frame_tracker tracker = new();
	int unsigned  reqs_sent = 0;
	int unsigned  sender_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  hold_left = 0;
	int unsigned  quiet_cycles = 0;

	debug_stream_deframer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #10 clk = ~clk;

	// result side: check accepted results, then pick next cycle's stall
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				tracker.check_result(out_res);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic void set_idle(idle_mode_t mode);
		sender_idle_pct = (mode == IDLE_SENDER) ? 76 : (mode == IDLE_BOTH) ? 28 : 0;
		recv_stall_pct  = (mode == IDLE_RECEIVER) ? 76 : (mode == IDLE_BOTH) ? 28 : 0;
	endfunction

	function automatic logic [95:0] pack_header(logic [31:0] magic, logic [7:0] ver,
	                                            logic [31:0] len);
		return {len, 8'($urandom), 8'($urandom), 8'($urandom), ver, magic};
	endfunction

	function automatic int unsigned pick_length(int unsigned lim);
		int unsigned r;
		if (lim == 0)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 3)
			return 0;
		if (r == 3)
			return (lim <= 64) ? lim : 64;
		return $urandom_range(1, (lim < 16) ? lim : 16);
	endfunction

	task automatic send_request(input logic cmd, input logic [7:0] b);
		in_req_t r;
		r.command = cmd;
		r.in_byte = b;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_req   <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_request(r);
		reqs_sent++;
	endtask

	task automatic send_header_bytes(input logic [95:0] hdr, input int first, input int final_idx);
		for (int i = first; i <= final_idx; i++)
			send_request(CMD_STREAM, hdr[8*i +: 8]);
	endtask

	task automatic send_frame(input logic [31:0] magic, input logic [7:0] ver,
	                          input logic [31:0] len, input int unsigned body);
		send_header_bytes(pack_header(magic, ver, len), 0, HDR_BYTES - 1);
		repeat (body)
			send_request(CMD_STREAM, 8'($urandom));
	endtask

	// pause the sender until every expected result is back and the pipe is quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.write_reg(addr, data);
	endtask

	task automatic send_bad_frame();
		logic [31:0] m;
		logic [7:0]  v;
		logic [31:0] len;
		m   = tracker.magic_cfg;
		v   = tracker.version_cfg;
		len = pick_length(tracker.max_len_cfg);
		case ($urandom_range(0, 2))
			0: m = m ^ (32'h1 << $urandom_range(0, 31));
			1: v = v ^ (8'h1 << $urandom_range(0, 7));
			default: begin
				// just over the limit, or further above it without passing all ones
				len = {8'h00, tracker.max_len_cfg} + 32'd1;
				if ($urandom_range(0, 1))
					len = len + $urandom_range(0, 32'hFEFFFFFF);
			end
		endcase
		send_frame(m, v, len, 0);
	endtask

	task automatic random_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		int unsigned lim;
		stop_at = reqs_sent + count;
		while (reqs_sent < stop_at) begin
			lim  = tracker.max_len_cfg;
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				len = pick_length(lim);
				send_frame(tracker.magic_cfg, tracker.version_cfg, len, len);
			end else if (pick < 75) begin
				send_bad_frame();
				repeat ($urandom_range(0, 3))
					send_request(CMD_STREAM, 8'($urandom));
				send_request(CMD_CLEAR, 8'($urandom));
			end else if (pick < 83) begin
				// frame cut short in its payload or in its header
				if (lim >= 2 && $urandom_range(0, 1)) begin
					len = $urandom_range(2, (lim < 16) ? lim : 16);
					send_frame(tracker.magic_cfg, tracker.version_cfg, len,
					           $urandom_range(1, len - 1));
				end else begin
					send_header_bytes(pack_header(tracker.magic_cfg, tracker.version_cfg,
					                              pick_length(lim)),
					                  0, $urandom_range(0, HDR_BYTES - 2));
				end
				send_request(CMD_CLEAR, 8'($urandom));
			end else if (pick < 90) begin
				send_request(CMD_CLEAR, 8'($urandom));
			end else begin
				repeat ($urandom_range(1, 4))
					send_request(CMD_STREAM, 8'($urandom));
				if ($urandom_range(0, 3) != 0)
					send_request(CMD_CLEAR, 8'($urandom));
			end
		end
	endtask

	initial begin
		logic [31:0]      m;
		logic [7:0]       v;
		logic [LEN_W-1:0] mx;
		logic [95:0]      hdr;
		int unsigned      len;

		set_idle(IDLE_NONE);
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty frame
		send_frame(MAGIC_WORD_RST, PROTO_VER_RST, 32'd0, 0);
		// wrong magic and version, length too big for 24 bits
		send_header_bytes({32'hFFFFFFFF, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF},
		                  0, HDR_BYTES - 1);
		send_request(CMD_STREAM, 8'hFF);
		send_request(CMD_CLEAR, 8'hFF);

		for (int s = 0; s < 6; s++) begin
			m  = $urandom;
			v  = 8'($urandom);
			mx = LEN_W'($urandom);
			case (s)
				0: begin
					m  = '1;
					v  = '1;
					mx = '1;
				end
				1: begin
					m  = '0;
					v  = '0;
					mx = '0;
				end
				2: mx = LEN_W'(20);
				3: mx = LEN_W'($urandom_range(1, 64));
				4: begin
					v  = PROTO_VER_RST;
					mx = MAX_PAYLOAD_RST;
				end
				default: ;
			endcase
			drain();
			apb_write(ADDR_MAGIC, m);
			apb_write(ADDR_VERSION, {24'h0, v});
			apb_write(ADDR_MAX_LEN, {8'h0, mx});
			set_idle(idle_mode_t'(s % 4));

			if (s == 2)
				hold_left = 400;   // receiver holds off while the sender keeps pushing

			if (s == 3) begin
				// magic changes between header bytes; the check uses the new value
				m   = $urandom;
				len = pick_length(tracker.max_len_cfg);
				hdr = pack_header(m, tracker.version_cfg, len);
				send_header_bytes(hdr, 0, HB_FLAGS);
				drain();
				apb_write(ADDR_MAGIC, m);
				apb_write(ADDR_UNMAPPED, $urandom);
				send_header_bytes(hdr, HB_RESERVED, HDR_BYTES - 1);
				repeat (len)
					send_request(CMD_STREAM, 8'($urandom));
			end

			random_traffic(160);
		end

		drain();
		if (tracker.pending_results.size() != 0) begin
			$error("%0d expected results never arrived", tracker.pending_results.size());
			tracker.mismatches++;
		end

		$display("covered %0d requests over seven register settings and four idle patterns",
		         reqs_sent);
		$display("checked %0d header, %0d payload and %0d error results, %0d mismatches",
		         tracker.n_header, tracker.n_payload, tracker.n_error, tracker.mismatches);
		if (tracker.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
